/* design/sfpg_pkg.sv */
// Shared types and constants for the stereo fade, play and pause gain block.
// Used by the divider, the scaler, the top level and the checker.
package sfpg_pkg;

	localparam int Q_W = 16;
	localparam int unsigned GAIN_ONE = 32768;
	localparam int FPB_W = 13;
	localparam int ACT_W = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [Q_W-1:0] FADE_STEP_RST = 16'd1638;
	localparam logic [FPB_W-1:0] FPB_RST = 13'd512;

	localparam logic [CFG_ADDR_W-1:0] REG_FADE_STEP = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_PER_BLOCK = 2'd1;

	localparam logic [ACT_W-1:0] ACT_FRAME = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PLAY = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PAUSE = 2'd2;

	typedef enum logic [3:0] {
		MODE_PAUSED   = 4'b0001,
		MODE_FADE_IN  = 4'b0010,
		MODE_PLAYING  = 4'b0100,
		MODE_FADE_OUT = 4'b1000
	} mode_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_STEP  = 6'b000100,
		ST_MUL_L = 6'b001000,
		ST_MUL_R = 6'b010000,
		ST_DONE  = 6'b100000
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

/* design/sfpg_divider.sv */
// Restoring divider that yields one quotient bit per cycle.
// Computes the per-frame ramp increment; depends on sfpg_pkg.
module sfpg_divider #(
	parameter int DVS_W = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [sfpg_pkg::Q_W-1:0] dividend,
	input  logic [DVS_W-1:0]        divisor,
	output sfpg_pkg::div_status_t   status,
	output logic [sfpg_pkg::Q_W-1:0] quotient
);
	import sfpg_pkg::*;

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DVS_W:0]   rem_q;
	logic [Q_W-1:0]   dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q[DVS_W-1:0], dvd_q[Q_W-1]};
	assign fits = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
			dvd_q <= {dvd_q[Q_W-2:0], fits};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient = dvd_q;

endmodule

/* design/sfpg_scaler.sv */
// Shared sample by gain multiplier with a floor shift by 15 and a registered result.
// Used for both channels in turn; depends on sfpg_pkg.
module sfpg_scaler #(
	parameter int SAMPLE_BITS = 16,
	parameter int GW = 28
) (
	input  logic                          clk,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [GW-1:0]                 gain,
	output logic signed [SAMPLE_BITS-1:0] result
);
	import sfpg_pkg::*;

	localparam int P_W = SAMPLE_BITS + GW + 1;

	logic signed [P_W-1:0] prod;

	assign prod = P_W'(sample) * P_W'($signed({1'b0, gain}));

	always_ff @(posedge clk) begin
		result <= prod[SAMPLE_BITS+14:15];
	end

endmodule

/* design/stereo_fade_play_pause_gain_top.sv */
// Top level of the stereo fade, play and pause gain block: sequencer and state.
// Depends on sfpg_pkg, sfpg_divider and sfpg_scaler.
//
// Each accepted word is a stereo frame, a play or pause request or an unused action. A
// request or unused action is taken without leaving the idle state and gives no result.
// A frame goes through the ST_STEP, ST_MUL_L, ST_MUL_R and ST_DONE states, and its result
// word is registered from ST_DONE once the output is free. On the first frame of a fading
// block it first waits in ST_DIV, because the one-bit-per-cycle divider works out the
// per-frame gain step. The next word can be taken in the same cycle as the result word
// appears. Both channels go through one shared multiplier in turn, left first, then right.
// The block takes no input while a frame is in work, and a finished result waits in the
// output register until it is taken.
module stereo_fade_play_pause_gain_top #(
	parameter int MAX_BLOCK_FRAMES = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// left_sample, right_sample
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]           s_tdata,
	// action
	input  logic [sfpg_pkg::ACT_W-1:0]                   s_tuser,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// left_out, right_out
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]           m_tdata,
	// engine_active
	output logic                                         m_tuser,
	output logic                                         m_tlast,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [sfpg_pkg::CFG_ADDR_W-1:0]              cfg_addr,
	input  logic [sfpg_pkg::CFG_DATA_W-1:0]              cfg_data
);
	import sfpg_pkg::*;

	localparam int POS_W = (MAX_BLOCK_FRAMES > 1) ? $clog2(MAX_BLOCK_FRAMES) : 1;
	localparam int LEN_W = POS_W + 1;
	localparam int GW = Q_W + POS_W;
	localparam int TD_W = ((2*SAMPLE_BITS+7)/8)*8;

	seq_state_t state_q;
	mode_t mode_q;
	mode_t mode_start;
	mode_t mode_end;
	logic [ACT_W-1:0] pend_q;
	logic [Q_W-1:0] fade_step_q;
	logic [FPB_W-1:0] fpb_q;
	logic [GW-1:0] gain_q;
	logic [Q_W-1:0] goal_q;
	logic [Q_W-1:0] inc_q;
	logic [POS_W-1:0] pos_q;
	logic last_q;
	logic signed [SAMPLE_BITS-1:0] lsmp_q;
	logic signed [SAMPLE_BITS-1:0] rsmp_q;
	logic signed [SAMPLE_BITS-1:0] lscl_q;
	logic signed [SAMPLE_BITS-1:0] lout_q;
	logic signed [SAMPLE_BITS-1:0] rout_q;
	logic m_valid_q;
	logic m_last_q;
	logic m_active_q;

	logic [LEN_W-1:0] blen;
	logic last_now;
	logic s_acc;
	logic frame_acc;
	logic out_free;
	logic [GW:0] sum_in;
	logic [Q_W-1:0] goal_in;
	logic [Q_W-1:0] goal_out;
	logic [Q_W-1:0] diff;
	logic div_start;
	div_status_t div_st;
	logic [Q_W-1:0] div_q;
	logic signed [SAMPLE_BITS-1:0] scl_in;
	logic signed [SAMPLE_BITS-1:0] scl_res;

	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_acc = s_tvalid && s_tready;
	assign frame_acc = s_acc && (s_tuser == ACT_FRAME);
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		if (fpb_q == '0) begin
			blen = LEN_W'(1);
		end else if (32'(fpb_q) > 32'(MAX_BLOCK_FRAMES)) begin
			blen = LEN_W'(MAX_BLOCK_FRAMES);
		end else begin
			blen = LEN_W'(fpb_q);
		end
	end

	assign last_now = ({1'b0, pos_q} + LEN_W'(1)) >= blen;

	always_comb begin
		mode_start = mode_q;
		if (pend_q == ACT_PLAY) begin
			mode_start = MODE_FADE_IN;
		end else if (pend_q == ACT_PAUSE) begin
			mode_start = MODE_FADE_OUT;
		end
		sum_in = {1'b0, gain_q} + (GW+1)'(fade_step_q);
		goal_in = (sum_in > (GW+1)'(GAIN_ONE)) ? Q_W'(GAIN_ONE) : sum_in[Q_W-1:0];
		goal_out = (gain_q > GW'(fade_step_q)) ? gain_q[Q_W-1:0] - fade_step_q : '0;
		diff = (mode_start == MODE_FADE_IN) ? goal_in - gain_q[Q_W-1:0]
			: gain_q[Q_W-1:0] - goal_out;
	end

	assign div_start = frame_acc && (pos_q == '0)
		&& (mode_start == MODE_FADE_IN || mode_start == MODE_FADE_OUT);

	always_comb begin
		mode_end = mode_q;
		if (last_q) begin
			if (mode_q == MODE_FADE_IN && gain_q == GW'(GAIN_ONE)) begin
				mode_end = MODE_PLAYING;
			end else if (mode_q == MODE_FADE_OUT && gain_q == '0) begin
				mode_end = MODE_PAUSED;
			end
		end
	end

	sfpg_divider #(
		.DVS_W(LEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(diff),
		.divisor(blen),
		.status(div_st),
		.quotient(div_q)
	);

	assign scl_in = (state_q == ST_MUL_L) ? lsmp_q : rsmp_q;

	sfpg_scaler #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.GW(GW)
	) u_scl (
		.clk(clk),
		.sample(scl_in),
		.gain(gain_q),
		.result(scl_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_PAUSED;
			pend_q <= ACT_FRAME;
			fade_step_q <= FADE_STEP_RST;
			fpb_q <= FPB_RST;
			gain_q <= '0;
			goal_q <= '0;
			inc_q <= '0;
			pos_q <= '0;
			last_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_addr)
					REG_FADE_STEP: fade_step_q <= cfg_data;
					REG_FRAMES_PER_BLOCK: fpb_q <= cfg_data[FPB_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == ACT_PLAY || s_tuser == ACT_PAUSE) begin
							pend_q <= s_tuser;
						end else if (s_tuser == ACT_FRAME) begin
							if (pos_q == '0) begin
								mode_q <= mode_start;
								pend_q <= ACT_FRAME;
								if (mode_start == MODE_FADE_IN) begin
									goal_q <= goal_in;
								end else if (mode_start == MODE_FADE_OUT) begin
									goal_q <= goal_out;
								end
							end
							state_q <= div_start ? ST_DIV : ST_STEP;
						end
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						inc_q <= div_q;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					last_q <= last_now;
					if (last_now && (mode_q == MODE_FADE_IN || mode_q == MODE_FADE_OUT)) begin
						gain_q <= GW'(goal_q);
					end else if (mode_q == MODE_FADE_IN) begin
						gain_q <= gain_q + GW'(inc_q);
					end else if (mode_q == MODE_FADE_OUT) begin
						gain_q <= (gain_q > GW'(inc_q)) ? gain_q - GW'(inc_q) : '0;
					end
					state_q <= ST_MUL_L;
				end
				ST_MUL_L: begin
					state_q <= ST_MUL_R;
				end
				ST_MUL_R: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						mode_q <= mode_end;
						pos_q <= last_q ? '0 : pos_q + POS_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			lsmp_q <= s_tdata[SAMPLE_BITS-1:0];
			rsmp_q <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		end
		if (state_q == ST_MUL_R) begin
			lscl_q <= scl_res;
		end
		if (state_q == ST_DONE && out_free) begin
			if (mode_q == MODE_FADE_IN || mode_q == MODE_FADE_OUT) begin
				lout_q <= lscl_q;
				rout_q <= scl_res;
			end else if (mode_q == MODE_PLAYING) begin
				lout_q <= lsmp_q;
				rout_q <= rsmp_q;
			end else begin
				lout_q <= '0;
				rout_q <= '0;
			end
			m_last_q <= last_q;
			m_active_q <= (mode_end != MODE_PAUSED);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = TD_W'({rout_q, lout_q});
	assign m_tuser = m_active_q;
	assign m_tlast = m_last_q;

endmodule

/* design/sfpg_checker.sv */
// Port-level assertions for the stereo fade, play and pause gain block.
// Bound to stereo_fade_play_pause_gain_top; depends on sfpg_pkg.
module sfpg_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
	input logic [sfpg_pkg::ACT_W-1:0]          s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
	input logic                                m_tuser,
	input logic                                m_tlast,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [sfpg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input logic [sfpg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sfpg_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	a_paused_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("paused output word is not silent");

	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_FRAME |=> !s_tready)
		else $error("frame word accepted without a busy period");

	a_request_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_PLAY || s_tuser == ACT_PAUSE)
		|=> s_tready && !$rose(m_tvalid))
		else $error("request word produced a result or stalled input");

endmodule

bind stereo_fade_play_pause_gain_top sfpg_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_sfpg_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stereo_fade_play_pause_gain_top: directed and random frame
// and request words, with every result word checked against an in-bench fade and gain model.
// Depends on sfpg_pkg and the design sources; reads no files.
module tb_top;
	import sfpg_pkg::*;

	localparam int MAX_FRAMES = 4096;
	localparam int DRAIN_CYCLES = 48;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SEGMENTS = 5;
	localparam int WORDS_PER_SEGMENT = 50;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [ACT_W-1:0] REQ_NONE = ACT_FRAME;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [15:0] left_out;
		logic [15:0] right_out;
		logic        engine_active;
		logic        block_end;
	} frame_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;
	logic [ACT_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Gain model state and its copy of the registers.
	logic [15:0]      fade_step_reg;
	logic [FPB_W-1:0] block_frames_reg;
	mode_t            mode_q;
	logic [ACT_W-1:0] pending_q;
	int unsigned      gain_q;
	int unsigned      goal_q;
	int unsigned      step_q;
	int unsigned      pos_q;

	frame_result_t expected_results[$];

	int src_idle_pct;
	int sink_stall_pct;
	int errors;
	int frames_sent;
	int requests_sent;
	int reg_writes;
	int results_checked;
	int cycles;

	stereo_fade_play_pause_gain_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("stereo_fade_play_pause_gain_top regression: fail");
			$finish;
		end
	end

	function automatic logic [15:0] apply_gain(input logic signed [15:0] smp,
			input int unsigned g);
		longint prod;
		prod = longint'(smp) * longint'(g);
		prod = prod >>> 15;
		return prod[15:0];
	endfunction

	function automatic void reset_model();
		fade_step_reg = FADE_STEP_RST;
		block_frames_reg = FPB_RST;
		mode_q = MODE_PAUSED;
		pending_q = REQ_NONE;
		gain_q = 0;
		goal_q = 0;
		step_q = 0;
		pos_q = 0;
	endfunction

	function automatic void predict_frame(input logic signed [15:0] left_s,
			input logic signed [15:0] right_s);
		int unsigned len;
		int unsigned goal;
		logic is_last;
		frame_result_t res;
		len = (block_frames_reg == 0) ? 1 : block_frames_reg;
		if (len > MAX_FRAMES)
			len = MAX_FRAMES;
		if (pos_q == 0) begin
			if (pending_q == ACT_PLAY)
				mode_q = MODE_FADE_IN;
			else if (pending_q == ACT_PAUSE)
				mode_q = MODE_FADE_OUT;
			pending_q = REQ_NONE;
			if (mode_q == MODE_FADE_IN) begin
				goal = gain_q + fade_step_reg;
				if (goal > GAIN_ONE)
					goal = GAIN_ONE;
				goal_q = goal;
				step_q = (goal - gain_q) / len;
			end else if (mode_q == MODE_FADE_OUT) begin
				goal = (gain_q > fade_step_reg) ? gain_q - fade_step_reg : 0;
				goal_q = goal;
				step_q = (gain_q - goal) / len;
			end
		end
		is_last = (pos_q + 1 >= len);
		res.left_out = '0;
		res.right_out = '0;
		if (mode_q == MODE_FADE_IN || mode_q == MODE_FADE_OUT) begin
			if (is_last)
				gain_q = goal_q;
			else if (mode_q == MODE_FADE_IN)
				gain_q = gain_q + step_q;
			else
				gain_q = (gain_q > step_q) ? gain_q - step_q : 0;
			res.left_out = apply_gain(left_s, gain_q);
			res.right_out = apply_gain(right_s, gain_q);
		end else if (mode_q == MODE_PLAYING) begin
			res.left_out = left_s;
			res.right_out = right_s;
		end
		if (is_last) begin
			pos_q = 0;
			if (mode_q == MODE_FADE_IN && gain_q == GAIN_ONE)
				mode_q = MODE_PLAYING;
			else if (mode_q == MODE_FADE_OUT && gain_q == 0)
				mode_q = MODE_PAUSED;
		end else begin
			pos_q = (pos_q + 1) % MAX_FRAMES;
		end
		res.engine_active = (mode_q != MODE_PAUSED);
		res.block_end = is_last;
		expected_results.push_back(res);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 50)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic check_word();
		frame_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result word, data %h", m_tdata));
			return;
		end
		want = expected_results.pop_front();
		results_checked++;
		if (m_tdata[15:0] !== want.left_out)
			report_mismatch($sformatf("left_out %h, want %h", m_tdata[15:0], want.left_out));
		if (m_tdata[31:16] !== want.right_out)
			report_mismatch($sformatf("right_out %h, want %h", m_tdata[31:16],
				want.right_out));
		if (m_tuser !== want.engine_active)
			report_mismatch($sformatf("engine_active %b, want %b", m_tuser,
				want.engine_active));
		if (m_tlast !== want.block_end)
			report_mismatch($sformatf("block_end %b, want %b", m_tlast, want.block_end));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_word();
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(input logic [ACT_W-1:0] act, input logic [15:0] left_s,
			input logic [15:0] right_s);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {right_s, left_s};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (act == ACT_FRAME) begin
			predict_frame(left_s, right_s);
			frames_sent++;
		end else if (act == ACT_PLAY || act == ACT_PAUSE) begin
			pending_q = act;
			requests_sent++;
		end
	endtask

	task automatic send_frame(input logic [15:0] left_s, input logic [15:0] right_s);
		send_word(ACT_FRAME, left_s, right_s);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (addr == REG_FADE_STEP)
			fade_step_reg = data;
		else if (addr == REG_FRAMES_PER_BLOCK)
			block_frames_reg = data[FPB_W-1:0];
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reset settings: silence while paused, then the start of a slow fade-in.
	task automatic test_power_up();
		send_frame(16'h7FFF, 16'h8000);
		send_word(ACT_UNUSED, 16'h1234, 16'h5678);
		send_word(ACT_PLAY, 16'h0000, 16'h0000);
		send_frame(16'h8000, 16'h7FFF);
		send_frame(16'hFFFF, 16'h0001);
	endtask

	// One-frame blocks with a full step: fades finish in one block, and requests
	// that match the mode, several requests in a block and the unused action.
	task automatic test_fast_fade();
		drain();
		write_reg(REG_FRAMES_PER_BLOCK, 16'd1);
		write_reg(REG_FADE_STEP, 16'd32768);
		send_frame(16'h4000, 16'hC000);
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h8000, 16'h7FFF);
		send_word(ACT_PLAY, 16'h0000, 16'h0000);
		send_frame(16'h1357, 16'hFEDC);
		send_word(ACT_PAUSE, 16'h0000, 16'h0000);
		send_frame(16'h7FFF, 16'h8000);
		send_word(ACT_PAUSE, 16'h0000, 16'h0000);
		send_frame(16'h2222, 16'hDDDD);
		send_word(ACT_PLAY, 16'h0000, 16'h0000);
		send_word(ACT_PAUSE, 16'h0000, 16'h0000);
		send_frame(16'h7FFF, 16'h7FFF);
		send_word(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
		send_frame(16'h8000, 16'h8000);
	endtask

	// Zero length and zero step, an oversized length, a length cut short mid-block
	// and writes to the unused register indexes.
	task automatic test_block_length_limits();
		drain();
		write_reg(REG_FRAMES_PER_BLOCK, 16'd0);
		write_reg(REG_FADE_STEP, 16'd0);
		write_reg(REG_SPARE_A, 16'hFFFF);
		send_word(ACT_PLAY, 16'h0000, 16'h0000);
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h1111, 16'h2222);
		drain();
		write_reg(REG_FRAMES_PER_BLOCK, 16'hFFFF);
		write_reg(REG_FADE_STEP, 16'd16384);
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h8000, 16'h7FFF);
		drain();
		write_reg(REG_FRAMES_PER_BLOCK, 16'd2);
		write_reg(REG_SPARE_B, 16'hA5A5);
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h4000, 16'hC000);
	endtask

	task automatic test_random_traffic();
		int src_pct [4] = '{0, 84, 0, 22};
		int sink_pct [4] = '{0, 0, 84, 22};
		int first_step [4] = '{32768, 1, 65535, 1638};
		int first_frames [4] = '{1, 4096, 0, 3};
		logic [15:0] step_val;
		logic [15:0] frames_val;
		logic [ACT_W-1:0] act;
		int n;
		int pick;
		for (int phase = 0; phase < 4; phase++) begin
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				drain();
				src_idle_pct = src_pct[phase];
				sink_stall_pct = sink_pct[phase];
				if (seg == 0) begin
					step_val = 16'(first_step[phase]);
					frames_val = 16'(first_frames[phase]);
				end else begin
					case ($urandom_range(5))
						0: step_val = 16'd32768;
						1: step_val = 16'd1;
						2: step_val = 16'hFFFF;
						3: step_val = 16'($urandom_range(8192, 32768));
						default: step_val = 16'($urandom_range(1, 32768));
					endcase
					case ($urandom_range(7))
						0: frames_val = 16'd1;
						1: frames_val = 16'($urandom);
						2: frames_val = 16'($urandom_range(7, 40));
						default: frames_val = 16'($urandom_range(1, 6));
					endcase
				end
				write_reg(REG_FADE_STEP, step_val);
				write_reg(REG_FRAMES_PER_BLOCK, frames_val);
				write_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B,
					16'($urandom));
				n = 0;
				while (n < WORDS_PER_SEGMENT) begin
					pick = $urandom_range(99);
					if (pick < 5)
						act = ACT_PLAY;
					else if (pick < 10)
						act = ACT_PAUSE;
					else if (pick < 12)
						act = ACT_UNUSED;
					else
						act = ACT_FRAME;
					send_word(act, rand_sample(), rand_sample());
					if (act != ACT_UNUSED)
						n++;
				end
			end
		end
		src_idle_pct = 0;
		sink_stall_pct = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_FRAME;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_addr <= REG_FADE_STEP;
		cfg_data <= '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		errors = 0;
		frames_sent = 0;
		requests_sent = 0;
		reg_writes = 0;
		results_checked = 0;
		cycles = 0;
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_up();
		test_fast_fade();
		test_block_length_limits();
		test_random_traffic();
		drain();
		$display("Sent %0d frames and %0d play or pause requests over %0d register writes.",
			frames_sent, requests_sent, reg_writes);
		$display("Checked %0d result words under four handshake pressure phases, %0d errors.",
			results_checked, errors);
		if (errors == 0)
			$display("stereo_fade_play_pause_gain_top regression: pass");
		else
			$display("stereo_fade_play_pause_gain_top regression: fail");
		$finish;
	end

endmodule
